[hdl/uartrx_pkg.sv]
package uartrx_pkg;

   localparam int unsigned CFG_W   = 16;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned BIT_IDX_W = 3;

   localparam logic [CFG_W-1:0] BIT_TIME_RESET    = 16'd104;
   localparam logic [CFG_W-1:0] FIRST_DELAY_RESET = 16'd156;

   // register indexes of the configuration port
   localparam int unsigned CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_BIT_TIME    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_DELAY = 1'b1;

   localparam logic [BIT_IDX_W-1:0] LAST_BIT = 3'd7;

   typedef enum logic [2:0] {
      PHASE_IDLE      = 3'b001,
      PHASE_RECEIVE   = 3'b010,
      PHASE_WAIT_HIGH = 3'b100
   } phase_type;

   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] data;
   } push_type;

endpackage

[hdl/uartrx_req_if.sv]
interface uartrx_req_if;
   logic valid;
   logic ready;
   logic rx_level;
   logic pop_req;

   modport source (output valid, output rx_level, output pop_req, input ready);
   modport sink   (input valid, input rx_level, input pop_req, output ready);
endinterface

[hdl/uartrx_rsp_if.sv]
interface uartrx_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [uartrx_pkg::BYTE_W-1:0] byte_out;
   logic                          byte_valid;
   logic                          available;

   modport source (output valid, output byte_out, output byte_valid, output available,
                   input ready);
   modport sink   (input valid, input byte_out, input byte_valid, input available,
                   output ready);
endinterface

[hdl/uartrx_ram.sv]
module uartrx_ram #(
   parameter int unsigned Width = 8,
   parameter int unsigned Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/uartrx_deser.sv]
module uartrx_deser (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic                         rx_level,
   input  logic [uartrx_pkg::CFG_W-1:0] bit_time,
   input  logic [uartrx_pkg::CFG_W-1:0] first_delay,
   output uartrx_pkg::push_type         push
);

   uartrx_pkg::phase_type                phase_ff, phase_in;
   logic [uartrx_pkg::CFG_W-1:0]         tick_ff, tick_in;
   logic [uartrx_pkg::BIT_IDX_W-1:0]     bit_idx_ff, bit_idx_in;
   logic [uartrx_pkg::BYTE_W-1:0]        shift_ff, shift_in;
   logic                                 prev_level_ff, prev_level_in;
   logic [uartrx_pkg::CFG_W-1:0]         tick_dec;
   logic [uartrx_pkg::BYTE_W-1:0]        shift_set;

   assign tick_dec  = tick_ff - uartrx_pkg::CFG_W'(1);
   assign shift_set = shift_ff
                      | (uartrx_pkg::BYTE_W'(rx_level) << bit_idx_ff);

   always_comb begin
      phase_in      = phase_ff;
      tick_in       = tick_ff;
      bit_idx_in    = bit_idx_ff;
      shift_in      = shift_ff;
      prev_level_in = prev_level_ff;
      push.valid    = 1'b0;
      push.data     = shift_set;
      if (accept) begin
         prev_level_in = rx_level;
         case (phase_ff)
            uartrx_pkg::PHASE_IDLE: begin
               if (prev_level_ff && !rx_level) begin
                  phase_in   = uartrx_pkg::PHASE_RECEIVE;
                  // a zero delay acts as one tick
                  tick_in    = (first_delay == '0) ? uartrx_pkg::CFG_W'(1) : first_delay;
                  bit_idx_in = '0;
                  shift_in   = '0;
               end
            end
            uartrx_pkg::PHASE_RECEIVE: begin
               tick_in = tick_dec;
               if (tick_dec == '0) begin
                  shift_in = shift_set;
                  if (bit_idx_ff == uartrx_pkg::LAST_BIT) begin
                     push.valid = 1'b1;
                     bit_idx_in = '0;
                     phase_in   = uartrx_pkg::PHASE_WAIT_HIGH;
                  end else begin
                     bit_idx_in = bit_idx_ff + uartrx_pkg::BIT_IDX_W'(1);
                     tick_in    = (bit_time == '0) ? uartrx_pkg::CFG_W'(1) : bit_time;
                  end
               end
            end
            uartrx_pkg::PHASE_WAIT_HIGH: begin
               if (rx_level) begin
                  phase_in = uartrx_pkg::PHASE_IDLE;
               end
            end
            default: begin
               phase_in = uartrx_pkg::PHASE_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= uartrx_pkg::PHASE_IDLE;
         tick_ff       <= '0;
         bit_idx_ff    <= '0;
         shift_ff      <= '0;
         prev_level_ff <= 1'b1;
      end else begin
         phase_ff      <= phase_in;
         tick_ff       <= tick_in;
         bit_idx_ff    <= bit_idx_in;
         shift_ff      <= shift_in;
         prev_level_ff <= prev_level_in;
      end
   end

endmodule

[hdl/uart_receiver_with_ring_fifo.sv]
// UART receiver for 8 data bits, LSB first, with a ring FIFO of FIFO_DEPTH-1
// bytes. Each request item is one sampler tick carrying the line level and a
// pop request; each tick yields exactly one response item with the popped byte
// (zero when nothing was popped), its valid flag and whether the FIFO still
// holds data. One item is taken every clock cycle unless the response stalls,
// and its response appears in the next cycle, set by the registered read of
// the FIFO RAM; the response register takes the next item in the same cycle
// its response is taken, so a stalled response holds off the input. bit_time
// and first_sample_delay (zero acts as one) are written through the csr port;
// the user must write them while no items are in flight (not enforced). A byte
// completed while the FIFO is full is dropped; the stop bit is not checked.
module uart_receiver_with_ring_fifo #(
   parameter int unsigned FIFO_DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [uartrx_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [uartrx_pkg::CFG_W-1:0]     csr_write_data,
   uartrx_req_if.sink                       req_chan,
   uartrx_rsp_if.source                     rsp_chan
);

   localparam int unsigned PtrW = $clog2(FIFO_DEPTH);

   function automatic logic [PtrW-1:0] advance(input logic [PtrW-1:0] p);
      advance = (p == PtrW'(FIFO_DEPTH - 1)) ? '0 : p + PtrW'(1);
   endfunction

   logic [uartrx_pkg::CFG_W-1:0] bit_time_ff, first_delay_ff;
   logic [PtrW-1:0]              wp_ff, wp_in, rp_ff, rp_in;
   logic                         out_valid_ff, out_valid_in;
   logic                         out_byte_valid_ff;
   logic                         out_available_ff;
   logic                         accept;
   logic                         pop_take;
   logic                         ram_wr_en;
   logic [uartrx_pkg::BYTE_W-1:0] ram_rd_data;
   uartrx_pkg::push_type         push;

   assign req_chan.ready = !reset && (!out_valid_ff || rsp_chan.ready);
   assign accept         = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_time_ff    <= uartrx_pkg::BIT_TIME_RESET;
         first_delay_ff <= uartrx_pkg::FIRST_DELAY_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            uartrx_pkg::CSR_BIT_TIME:    bit_time_ff    <= csr_write_data;
            uartrx_pkg::CSR_FIRST_DELAY: first_delay_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   uartrx_deser u_deser (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .rx_level    (req_chan.rx_level),
      .bit_time    (bit_time_ff),
      .first_delay (first_delay_ff),
      .push        (push)
   );

   // pop first, then push against the updated read pointer
   assign pop_take  = accept && req_chan.pop_req && (wp_ff != rp_ff);
   assign rp_in     = pop_take ? advance(rp_ff) : rp_ff;
   assign ram_wr_en = push.valid && (advance(wp_ff) != rp_in);
   assign wp_in     = ram_wr_en ? advance(wp_ff) : wp_ff;

   uartrx_ram #(
      .Width (uartrx_pkg::BYTE_W),
      .Depth (FIFO_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wp_ff),
      .wr_data (push.data),
      .rd_en   (pop_take),
      .rd_addr (rp_ff),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      out_valid_in = out_valid_ff;
      if (accept) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= '0;
         rp_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         out_byte_valid_ff <= pop_take;
         out_available_ff  <= (wp_in != rp_in);
      end
   end

   // RAM read data holds until the next pop, so a stalled response keeps its byte
   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.byte_valid = out_byte_valid_ff;
   assign rsp_chan.byte_out   = out_byte_valid_ff ? ram_rd_data : '0;
   assign rsp_chan.available  = out_available_ff;

   a_no_rw_same_entry: assert property (@(posedge clock) disable iff (reset)
      !(ram_wr_en && pop_take && (wp_ff == rp_ff)))
      else $error("FIFO write and read hit the same entry");

   a_pop_reports_byte: assert property (@(posedge clock) disable iff (reset)
      pop_take |=> (out_valid_ff && out_byte_valid_ff))
      else $error("popped byte not reported");

   a_available_tracks_ptrs: assert property (@(posedge clock) disable iff (reset)
      $past(accept) |-> (out_available_ff == (wp_ff != rp_ff)))
      else $error("available flag disagrees with FIFO pointers");

   a_push_only_on_item: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> accept)
      else $error("FIFO written without an accepted item");

endmodule
